### design/psd_pkg.sv
package psd_pkg;

    // Field and datapath widths
    localparam int AXIS_W      = 14;
    localparam int TIME_W      = 32;
    localparam int MAG_W       = 14;
    localparam int SUMSQ_W     = 28;
    localparam int REM_W       = 17;
    localparam int COEF_W      = 6;
    localparam int ACC_W       = 22;
    localparam int FILT_W      = 19;
    localparam int SLOPE_W     = 17;
    localparam int DROP_W      = 18;
    localparam int LEVEL_W     = 19;
    localparam int SLOPE_THR_W = 16;
    localparam int RUN_W       = 8;
    localparam int MODE_W      = 2;
    localparam int CNT_W       = 4;

    // Window depths and sequencing
    localparam int FILTER_TAPS       = 9;
    localparam int FILT_DEPTH        = 6;
    localparam int SLOPE_DEPTH       = 5;
    localparam int REFRACTORY        = 8;
    localparam int SQUARE_STEPS      = 3;
    localparam int ROOT_CYCLES       = 7;
    localparam int HISTORY_DEPTH_DEF = 150;

    // Stream and register port widths
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - 1 - TIME_W - MODE_W;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [LEVEL_W-1:0]     LEVEL_RST = LEVEL_W'(2000);
    localparam logic [SLOPE_THR_W-1:0] SLOPE_RST = SLOPE_THR_W'(250);
    localparam logic [RUN_W-1:0]       RUN_RST   = RUN_W'(8);
    localparam logic [TIME_W-1:0]      REST_RST  = TIME_W'(5000);

    // Low-pass taps in the order they pass the read point of the rotating
    // magnitude window (newest first, then oldest back toward newest)
    localparam logic [COEF_W-1:0] TAP_COEF [FILTER_TAPS] = '{
        6'd1, 6'd1, 6'd6, 6'd22, 6'd44, 6'd54, 6'd44, 6'd22, 6'd6
    };

    typedef enum logic [1:0] {
        REG_LEVEL = 2'd0,
        REG_SLOPE = 2'd1,
        REG_RUN   = 2'd2,
        REG_REST  = 2'd3
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_REST = 2'd0,
        MODE_WALK = 2'd1,
        MODE_RUN  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_FILTER,
        S_DECIDE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]     level_threshold;
        logic [SLOPE_THR_W-1:0] slope_threshold;
        logic [RUN_W-1:0]       running_threshold;
        logic [TIME_W-1:0]      rest_time_ms;
    } cfg_t;

    typedef struct packed {
        logic             load;
        logic             square;
        logic             root;
        logic             root_last;
        logic             filter;
        logic             filter_last;
        logic             decide;
        logic             emit;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

endpackage

### design/psd_regs.sv
module psd_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [psd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [psd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output psd_pkg::cfg_t                    cfg
);
    import psd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes, masked to register width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level_threshold   <= LEVEL_RST;
            cfg_reg.slope_threshold   <= SLOPE_RST;
            cfg_reg.running_threshold <= RUN_RST;
            cfg_reg.rest_time_ms      <= REST_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_LEVEL: cfg_reg.level_threshold   <= pwdata[LEVEL_W-1:0];
                REG_SLOPE: cfg_reg.slope_threshold   <= pwdata[SLOPE_THR_W-1:0];
                REG_RUN:   cfg_reg.running_threshold <= pwdata[RUN_W-1:0];
                REG_REST:  cfg_reg.rest_time_ms      <= pwdata[TIME_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            REG_LEVEL: prdata = APB_DATA_W'(cfg_reg.level_threshold);
            REG_SLOPE: prdata = APB_DATA_W'(cfg_reg.slope_threshold);
            REG_RUN:   prdata = APB_DATA_W'(cfg_reg.running_threshold);
            REG_REST:  prdata = APB_DATA_W'(cfg_reg.rest_time_ms);
        endcase
    end

endmodule

### design/psd_datapath.sv
module psd_datapath #(
    parameter int HISTORY_DEPTH = psd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  psd_pkg::cmd_t                  cmd,
    input  psd_pkg::cfg_t                  cfg,
    input  logic [psd_pkg::S_TDATA_W-1:0]  s_word,
    output logic [psd_pkg::M_TDATA_W-1:0]  m_word
);
    import psd_pkg::*;

    localparam int HIST_CNT_W = $clog2(HISTORY_DEPTH + 1);

    // one restoring square-root digit: brings in two radicand bits
    function automatic logic [REM_W+MAG_W-1:0] root_step(
        input logic [REM_W-1:0] rem,
        input logic [MAG_W-1:0] root,
        input logic [1:0]       pair
    );
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] trial;
        r     = {rem[REM_W-3:0], pair};
        trial = REM_W'({root, 2'b01});
        if (r >= trial) begin
            return {r - trial, root[MAG_W-2:0], 1'b1};
        end else begin
            return {r, root[MAG_W-2:0], 1'b0};
        end
    endfunction

    // sample and working registers
    logic signed [AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [SUMSQ_W-1:0]       rad_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [MAG_W-1:0]         root_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic                     step_reg;
    logic [M_TDATA_W-1:0]     out_reg;

    // detector state
    logic [MAG_W-1:0]          mag_reg   [FILTER_TAPS];
    logic [FILT_W-1:0]         filt_reg  [FILT_DEPTH];
    logic signed [SLOPE_W-1:0] slope_reg [SLOPE_DEPTH];
    logic [HISTORY_DEPTH-1:0]  hist_reg;
    logic [HIST_CNT_W-1:0]     count_reg;
    logic [TIME_W-1:0]         total_reg;
    logic [TIME_W-1:0]         last_reg;

    logic signed [AXIS_W-1:0]    sq_sel;
    logic signed [SUMSQ_W-1:0]   sq_full;
    logic [REM_W+MAG_W-1:0]      st1, st2;
    logic [ACC_W-1:0]            prod, acc_sum;
    logic signed [15:0]          lo_new, lo_old;
    logic signed [SLOPE_W-1:0]   slope_new;
    logic signed [DROP_W-1:0]    drop, drop_thr;
    logic                        sign_chg, level_ok, recent, step_now;
    logic [HIST_CNT_W-1:0]       count_next;
    logic [TIME_W-1:0]           elapsed;
    mode_t                       mode_now;

    // shared squarer, one axis per cycle
    always_comb begin
        case (cmd.cnt[1:0])
            2'd0:    sq_sel = ax_reg;
            2'd1:    sq_sel = ay_reg;
            default: sq_sel = az_reg;
        endcase
    end
    assign sq_full = sq_sel * sq_sel;

    // two root digits per cycle
    assign st1 = root_step(rem_reg, root_reg, rad_reg[SUMSQ_W-1 -: 2]);
    assign st2 = root_step(st1[REM_W+MAG_W-1:MAG_W], st1[MAG_W-1:0],
                           rad_reg[SUMSQ_W-3 -: 2]);

    // filter MAC on the window read point
    assign prod    = ACC_W'(TAP_COEF[cmd.cnt] * mag_reg[0]);
    assign acc_sum = ((cmd.cnt == '0) ? '0 : acc_reg) + prod;

    // slope from the window as it stands before this shift
    assign lo_new    = filt_reg[2][15:0];
    assign lo_old    = filt_reg[4][15:0];
    assign slope_new = SLOPE_W'(lo_new) - SLOPE_W'(lo_old);

    // step decision
    assign sign_chg = (slope_reg[0] < 0 && slope_reg[1] > 0) ||
                      (slope_reg[0] > 0 && slope_reg[1] < 0);
    assign drop     = DROP_W'(slope_reg[4]) - DROP_W'(slope_reg[0]);
    assign drop_thr = $signed({2'b00, cfg.slope_threshold});
    assign level_ok = filt_reg[4] > cfg.level_threshold;
    assign recent   = |hist_reg[REFRACTORY-1:0];
    assign step_now = sign_chg && level_ok && (drop > drop_thr) && !recent;
    assign count_next = count_reg + HIST_CNT_W'(step_now)
                      - HIST_CNT_W'(hist_reg[HISTORY_DEPTH-1]);

    // activity mode from updated state
    assign elapsed = now_reg - last_reg;
    always_comb begin
        if (elapsed > cfg.rest_time_ms) begin
            mode_now = MODE_REST;
        end else if (RUN_W'(count_reg) > cfg.running_threshold) begin
            mode_now = MODE_RUN;
        end else begin
            mode_now = MODE_WALK;
        end
    end

    // windows, history and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < FILTER_TAPS; k++) mag_reg[k] <= '0;
            for (int k = 0; k < FILT_DEPTH; k++) filt_reg[k] <= '0;
            for (int k = 0; k < SLOPE_DEPTH; k++) slope_reg[k] <= '0;
            hist_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
            last_reg  <= '0;
        end else begin
            if (cmd.root_last) begin
                mag_reg[0] <= st2[MAG_W-1:0];
                for (int k = 1; k < FILTER_TAPS; k++) mag_reg[k] <= mag_reg[k-1];
            end else if (cmd.filter) begin
                // a full turn of nine leaves the window in order
                mag_reg[0] <= mag_reg[FILTER_TAPS-1];
                for (int k = 1; k < FILTER_TAPS; k++) mag_reg[k] <= mag_reg[k-1];
            end
            if (cmd.filter_last) begin
                filt_reg[0]  <= acc_sum[ACC_W-1:3];
                for (int k = 1; k < FILT_DEPTH; k++) filt_reg[k] <= filt_reg[k-1];
                slope_reg[0] <= slope_new;
                for (int k = 1; k < SLOPE_DEPTH; k++) slope_reg[k] <= slope_reg[k-1];
            end
            if (cmd.decide) begin
                hist_reg  <= {hist_reg[HISTORY_DEPTH-2:0], step_now};
                count_reg <= count_next;
                if (step_now) begin
                    total_reg <= total_reg + TIME_W'(1);
                    last_reg  <= now_reg;
                end
            end
        end
    end

    // sample capture, square, root, MAC and result word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg   <= s_word[AXIS_W-1:0];
            ay_reg   <= s_word[2*AXIS_W-1:AXIS_W];
            az_reg   <= s_word[3*AXIS_W-1:2*AXIS_W];
            now_reg  <= s_word[3*AXIS_W+TIME_W-1:3*AXIS_W];
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.square) begin
            rad_reg <= rad_reg + $unsigned(sq_full);
        end
        if (cmd.root) begin
            rad_reg  <= rad_reg << 4;
            rem_reg  <= st2[REM_W+MAG_W-1:MAG_W];
            root_reg <= st2[MAG_W-1:0];
        end
        if (cmd.filter) begin
            acc_reg <= acc_sum;
        end
        if (cmd.decide) begin
            step_reg <= step_now;
        end
        if (cmd.emit) begin
            out_reg <= {M_PAD_W'(0), mode_now, total_reg, step_reg};
        end
    end

    assign m_word = out_reg;

endmodule

### design/psd_ctrl.sv
module psd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output psd_pkg::cmd_t cmd
);
    import psd_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // sequencing of load, square, root, filter, decision and result phases
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        if (m_tready) valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE: begin
                cmd.square = 1'b1;
                if (cnt_reg == CNT_W'(SQUARE_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_ROOT: begin
                cmd.root = 1'b1;
                if (cnt_reg == CNT_W'(ROOT_CYCLES - 1)) begin
                    cmd.root_last = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_FILTER;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_FILTER: begin
                cmd.filter = 1'b1;
                if (cnt_reg == CNT_W'(FILTER_TAPS - 1)) begin
                    cmd.filter_last = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_DECIDE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // load the result word once the output slot is free
                if (!valid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after a word");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_EMIT))
        else $error("result valid raised outside the result phase");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && m_tvalid && !m_tready) |=> state_reg == S_EMIT)
        else $error("pending result would be overwritten");

    a_filter_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILTER) |-> (cnt_reg < CNT_W'(FILTER_TAPS)))
        else $error("filter tap counter out of range");
`endif

endmodule

### design/pedometer_step_detector_core.sv
// Step detector for a three-axis accelerometer. Each input word carries one
// sample and a millisecond timestamp; each yields exactly one result word
// with the step flag, the running step total and the rest/walk/run mode.
// A sample passes from acceptance to its result through an accept state,
// the shared 14x14 squarer, the square-root unit (two digits per cycle),
// the single low-pass multiply-accumulate, a decision state and the load
// of the output register. The next sample is accepted as soon as the
// result is loaded, even while that result still waits on m_axis_tready;
// a result waits in the last phase only while the previous one is still
// held. All detector state is cleared by reset; no clearing pass is needed.
// The user must write registers over the APB port only while no sample is
// in flight; the block itself does not enforce it.
module pedometer_step_detector_core #(
    parameter int HISTORY_DEPTH = psd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // axis_x [13:0], axis_y [27:14], axis_z [41:28], now_ms [73:42]
    input  logic [psd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // step_seen [0], step_total [32:1], activity_mode [34:33]
    output logic [psd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [psd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [psd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import psd_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    // configuration registers
    psd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // phase sequencer
    psd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd)
    );

    // arithmetic and detector state
    psd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (cfg),
        .s_word  (s_axis_tdata),
        .m_word  (m_axis_tdata)
    );

endmodule
